[rtl/rtps_pkg.sv]
// Shared types, constants and helpers for the RTOS priority task scheduler.
package rtps_pkg;

   localparam int NUM_TASKS  = 32;
   localparam int IDLE_TASK  = 31;
   localparam int TASK_SLOTS = 32;

   localparam logic [4:0]  LAST_TASK = 5'(NUM_TASKS - 1);
   localparam logic [31:0] TASK_MASK = 32'((64'd1 << NUM_TASKS) - 64'd1);
   localparam logic [4:0]  IDLE_ID   = 5'(IDLE_TASK);
   localparam logic        IDLE_OK   = (IDLE_TASK < NUM_TASKS);

   typedef enum logic [2:0] {
      KIND_TICK      = 3'd0,
      KIND_DELAY     = 3'd1,
      KIND_SUSPEND   = 3'd2,
      KIND_RESUME    = 3'd3,
      KIND_CREATE    = 3'd4,
      KIND_START     = 3'd5,
      KIND_INT_ENTER = 3'd6,
      KIND_INT_EXIT  = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  task_id;
      logic [31:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic        switched;
      logic        switch_from_interrupt;
      logic [4:0]  previous_task;
      logic [4:0]  current_task;
      logic [31:0] ready_mask;
      logic [31:0] system_time;
   } rsp_type;

   typedef struct packed {
      logic        rd_en;
      logic [4:0]  rd_addr;
      logic        wr_en;
      logic [4:0]  wr_addr;
      logic [31:0] wr_data;
   } dmem_req_type;

   function automatic logic [4:0] first_set(input logic [31:0] bits);
      logic [4:0] idx;
      idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (bits[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/rtps_delay_store.sv]
// Per-task delay counter memory with registered read and reset valid bits.
module rtps_delay_store (
   input  logic                  clock,
   input  logic                  reset,
   input  rtps_pkg::dmem_req_type mem_req,
   output logic [31:0]           rd_data
);

   logic [31:0]                     dly_mem [rtps_pkg::TASK_SLOTS];
   logic [rtps_pkg::TASK_SLOTS-1:0] vld_ff;
   logic [rtps_pkg::TASK_SLOTS-1:0] vld_in;
   logic [31:0]                     rd_raw_ff;
   logic                            rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (mem_req.wr_en) begin
         vld_in[mem_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         dly_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_raw_ff <= dly_mem[mem_req.rd_addr];
         rd_vld_ff <= vld_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

[rtl/rtos_priority_task_scheduler.sv]
// Top level of the bitmap priority task scheduler with tick-driven delays.
//
// Usage:
//   req_* carries one scheduler event per beat (tick, delay, suspend, resume,
//   create, start, interrupt enter, interrupt exit). rsp_* returns exactly one
//   result beat per event: switch flags, previous and current task, the ready
//   bitmap and the tick count. Both channels use valid/ready.
//   A non-tick event passes from acceptance through the execute and done states
//   into the output register; the next event is accepted once the block is
//   back in idle. A tick walks all NUM_TASKS delay counters through the delay
//   memory, one entry per cycle (read, decrement, write back), and then moves
//   to the done state, from which its result goes to the output register.
//   One event is in work at a time.
//   A new event is accepted while a finished result still waits on rsp_*;
//   it runs up to its own result and then holds until the output register
//   frees. A stalled receiver therefore stalls req_ready after one event.
//   Reset clears the ready bitmap, running task, started flag, interrupt
//   nesting and tick count; the delay memory reads as zero until written.
module rtos_priority_task_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rtps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtps_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   rtps_pkg::req_type      req_ff, req_in;
   logic [31:0]            ready_ff, ready_in;
   logic [4:0]             run_ff, run_in;
   logic                   started_ff, started_in;
   logic [7:0]             nest_ff, nest_in;
   logic [31:0]            tick_ff, tick_in;
   logic [4:0]             idx_ff, idx_in;
   rtps_pkg::rsp_type      res_ff, res_in;
   rtps_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rtps_pkg::dmem_req_type mem_req;
   logic [31:0]            mem_rd_data;

   rtps_delay_store u_delay_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      logic        do_sched;
      logic        id_ok;
      logic [31:0] rdy;
      logic [4:0]  pick;
      logic        sw;
      logic [31:0] id_bit;
      logic [31:0] run_bit;

      state_in     = state_ff;
      req_in       = req_ff;
      ready_in     = ready_ff;
      run_in       = run_ff;
      started_in   = started_ff;
      nest_in      = nest_ff;
      tick_in      = tick_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_req      = '0;

      do_sched = 1'b0;
      id_ok    = (32'(req_ff.task_id) < 32'(rtps_pkg::NUM_TASKS));
      rdy      = ready_ff;
      pick     = '0;
      sw       = 1'b0;
      id_bit   = 32'd1 << req_ff.task_id;
      run_bit  = 32'd1 << run_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (req_ff.kind)
               rtps_pkg::KIND_TICK: begin
               end
               rtps_pkg::KIND_DELAY: begin
                  if (req_ff.delay_ticks != '0) begin
                     rdy             = rdy & ~run_bit;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = run_ff;
                     mem_req.wr_data = req_ff.delay_ticks;
                     do_sched        = 1'b1;
                  end
               end
               rtps_pkg::KIND_SUSPEND: begin
                  if (id_ok) begin
                     rdy             = rdy & ~id_bit;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req_ff.task_id;
                     do_sched        = (run_ff == req_ff.task_id);
                  end
               end
               rtps_pkg::KIND_RESUME: begin
                  if (id_ok) begin
                     rdy             = rdy | id_bit;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req_ff.task_id;
                     do_sched        = (run_ff > req_ff.task_id);
                  end
               end
               rtps_pkg::KIND_CREATE: begin
                  if (id_ok) begin
                     rdy             = rdy | id_bit;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req_ff.task_id;
                  end
               end
               rtps_pkg::KIND_START: begin
                  if (!started_ff) begin
                     started_in = 1'b1;
                     if (rtps_pkg::IDLE_OK) begin
                        rdy             = rdy | (32'd1 << rtps_pkg::IDLE_ID);
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = rtps_pkg::IDLE_ID;
                     end
                     do_sched = 1'b1;
                  end
               end
               rtps_pkg::KIND_INT_ENTER: begin
                  if (nest_ff != 8'hFF) begin
                     nest_in = nest_ff + 8'd1;
                  end
               end
               rtps_pkg::KIND_INT_EXIT: begin
                  if (nest_ff != '0) begin
                     nest_in = nest_ff - 8'd1;
                  end
                  do_sched = (nest_in == '0);
               end
               default: begin
               end
            endcase

            rdy  = rdy & rtps_pkg::TASK_MASK;
            pick = rtps_pkg::first_set(rdy);
            sw   = do_sched && (rdy != '0) && (pick != run_ff);

            if (req_ff.kind == rtps_pkg::KIND_TICK) begin
               tick_in         = tick_ff + 32'd1;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = '0;
               idx_in          = '0;
               state_in        = ST_SWEEP;
            end else begin
               ready_in                     = rdy;
               run_in                       = sw ? pick : run_ff;
               res_in.switched              = sw;
               res_in.switch_from_interrupt = sw && (req_ff.kind == rtps_pkg::KIND_INT_EXIT);
               res_in.previous_task         = run_ff;
               res_in.current_task          = run_in;
               res_in.ready_mask            = rdy;
               res_in.system_time           = tick_ff;
               state_in                     = ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (mem_rd_data != '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff;
               mem_req.wr_data = mem_rd_data - 32'd1;
               if (mem_rd_data == 32'd1) begin
                  ready_in[idx_ff] = 1'b1;
               end
            end
            if (idx_ff == rtps_pkg::LAST_TASK) begin
               res_in.switched              = 1'b0;
               res_in.switch_from_interrupt = 1'b0;
               res_in.previous_task         = run_ff;
               res_in.current_task          = run_ff;
               res_in.ready_mask            = ready_in & rtps_pkg::TASK_MASK;
               res_in.system_time           = tick_ff;
               state_in                     = ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff + 5'd1;
               idx_in          = idx_ff + 5'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= '0;
         run_ff       <= '0;
         started_ff   <= 1'b0;
         nest_ff      <= '0;
         tick_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         run_ff       <= run_in;
         started_ff   <= started_in;
         nest_ff      <= nest_in;
         tick_ff      <= tick_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sim/rtps_checker.sv]
// Checker for the priority task scheduler: predicts each result beat and compares it.
module rtps_checker
   import rtps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      results_checked,
   output int      switches_seen
);

   logic [31:0] ready_set;
   logic [31:0] delay_left [TASK_SLOTS];
   logic [4:0]  running;
   logic        started;
   logic [7:0]  nesting;
   logic [31:0] tick_total;
   rsp_type     sched_results_q [$];

   task automatic report_mismatch(input string msg);
      if (fail_count < 100) begin
         $display("mismatch: %s", msg);
      end
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   results_checked, name, got, want));
      end
   endtask

   function automatic logic reschedule();
      logic [31:0] cand;
      logic [4:0]  pick;
      logic        found;
      cand  = ready_set & TASK_MASK;
      pick  = '0;
      found = 1'b0;
      for (int i = 0; i < 32; i++) begin
         if (!found && cand[i]) begin
            pick  = 5'(i);
            found = 1'b1;
         end
      end
      if (!found || pick == running) begin
         return 1'b0;
      end
      running = pick;
      return 1'b1;
   endfunction

   task automatic step_scheduler(input req_type ev, output rsp_type res);
      logic changed;
      logic from_irq;
      changed  = 1'b0;
      from_irq = 1'b0;
      res.previous_task = running;
      case (ev.kind)
         KIND_TICK: begin
            tick_total = tick_total + 32'd1;
            for (int i = 0; i < NUM_TASKS && i < 32; i++) begin
               if (delay_left[i] != 32'd0) begin
                  delay_left[i] = delay_left[i] - 32'd1;
                  if (delay_left[i] == 32'd0) begin
                     ready_set[i] = 1'b1;
                  end
               end
            end
         end
         KIND_DELAY: begin
            if (ev.delay_ticks != 32'd0) begin
               ready_set[running]  = 1'b0;
               delay_left[running] = ev.delay_ticks;
               changed = reschedule();
            end
         end
         KIND_SUSPEND: begin
            if (int'(ev.task_id) < NUM_TASKS) begin
               delay_left[ev.task_id] = '0;
               ready_set[ev.task_id]  = 1'b0;
               if (running == ev.task_id) begin
                  changed = reschedule();
               end
            end
         end
         KIND_RESUME: begin
            if (int'(ev.task_id) < NUM_TASKS) begin
               delay_left[ev.task_id] = '0;
               ready_set[ev.task_id]  = 1'b1;
               if (running > ev.task_id) begin
                  changed = reschedule();
               end
            end
         end
         KIND_CREATE: begin
            if (int'(ev.task_id) < NUM_TASKS) begin
               delay_left[ev.task_id] = '0;
               ready_set[ev.task_id]  = 1'b1;
            end
         end
         KIND_START: begin
            if (!started) begin
               started = 1'b1;
               if (IDLE_OK) begin
                  delay_left[IDLE_ID] = '0;
                  ready_set[IDLE_ID]  = 1'b1;
               end
               changed = reschedule();
            end
         end
         KIND_INT_ENTER: begin
            if (nesting != 8'hFF) begin
               nesting = nesting + 8'd1;
            end
         end
         default: begin
            if (nesting != 8'd0) begin
               nesting = nesting - 8'd1;
            end
            if (nesting == 8'd0) begin
               changed  = reschedule();
               from_irq = changed;
            end
         end
      endcase
      ready_set = ready_set & TASK_MASK;
      res.switched              = changed;
      res.switch_from_interrupt = from_irq;
      res.current_task          = running;
      res.ready_mask            = ready_set;
      res.system_time           = tick_total;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type predicted;
      if (reset) begin
         ready_set  = '0;
         running    = '0;
         started    = 1'b0;
         nesting    = '0;
         tick_total = '0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            delay_left[i] = '0;
         end
         sched_results_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sched_results_q.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing expected: 0x%0h",
                                         rsp_data));
            end else begin
               want = sched_results_q.pop_front();
               check_field("switched", 32'(rsp_data.switched), 32'(want.switched));
               check_field("switch_from_interrupt", 32'(rsp_data.switch_from_interrupt),
                           32'(want.switch_from_interrupt));
               check_field("previous_task", 32'(rsp_data.previous_task),
                           32'(want.previous_task));
               check_field("current_task", 32'(rsp_data.current_task),
                           32'(want.current_task));
               check_field("ready_mask", rsp_data.ready_mask, want.ready_mask);
               check_field("system_time", rsp_data.system_time, want.system_time);
               results_checked++;
            end
         end
         if (req_valid && req_ready) begin
            step_scheduler(req_data, predicted);
            if (predicted.switched) begin
               switches_seen++;
            end
            sched_results_q.push_back(predicted);
         end
      end
      pending = sched_results_q.size();
   end

endmodule

[sim/rtos_priority_task_scheduler_tb.sv]
// Testbench top for the priority task scheduler: stimulus, flow control and verdict.
module rtos_priority_task_scheduler_tb;
   import rtps_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int results_checked;
   int switches_seen;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_done     = 0;
   int events_sent    = 0;

   rtos_priority_task_scheduler DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rtps_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .switches_seen   (switches_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : sink
      int n;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            for (n = 0; n < 600; n++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_event(input req_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      events_sent++;
   endtask

   task automatic send_kind(input kind_type k, input logic [4:0] id,
                            input logic [31:0] ticks);
      req_type ev;
      ev.kind        = k;
      ev.task_id     = id;
      ev.delay_ticks = ticks;
      send_event(ev);
   endtask

   function automatic req_type random_event();
      req_type ev;
      int      r;
      int      t;
      r = $urandom_range(99);
      t = $urandom_range(99);
      if (r < 34)       ev.kind = KIND_TICK;
      else if (r < 48)  ev.kind = KIND_DELAY;
      else if (r < 58)  ev.kind = KIND_SUSPEND;
      else if (r < 68)  ev.kind = KIND_RESUME;
      else if (r < 78)  ev.kind = KIND_CREATE;
      else if (r < 81)  ev.kind = KIND_START;
      else if (r < 89)  ev.kind = KIND_INT_ENTER;
      else              ev.kind = KIND_INT_EXIT;
      ev.task_id = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                            : 5'($urandom_range(7));
      ev.delay_ticks = $urandom();
      if (ev.kind == KIND_DELAY) begin
         if (t < 70)      ev.delay_ticks = $urandom_range(6, 1);
         else if (t < 80) ev.delay_ticks = '0;
         else if (t < 90) ev.delay_ticks = $urandom_range(40, 7);
      end
      return ev;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_kind(KIND_TICK,      5'd0,  32'hFFFF_FFFF);
      send_kind(KIND_INT_EXIT,  5'd31, 32'h0);
      send_kind(KIND_CREATE,    5'd3,  32'h0);
      send_kind(KIND_CREATE,    5'd31, 32'hA5A5_5A5A);
      send_kind(KIND_SUSPEND,   5'd0,  32'h5A5A_A5A5);
      send_kind(KIND_RESUME,    5'd0,  32'h0);
      send_kind(KIND_DELAY,     5'd0,  32'h0);
      send_kind(KIND_DELAY,     5'd31, 32'hFFFF_FFFF);
      send_kind(KIND_START,     5'd0,  32'h0);
      send_kind(KIND_START,     5'd7,  32'h1234_5678);
      send_kind(KIND_DELAY,     5'd0,  32'd1);
      send_kind(KIND_INT_ENTER, 5'd0,  32'h0);
      send_kind(KIND_TICK,      5'd0,  32'h0);
      send_kind(KIND_INT_EXIT,  5'd0,  32'h0);
      send_kind(KIND_INT_ENTER, 5'd0,  32'h0);
      send_kind(KIND_INT_ENTER, 5'd0,  32'h0);
      send_kind(KIND_INT_EXIT,  5'd0,  32'h0);
      send_kind(KIND_INT_EXIT,  5'd0,  32'h0);
      send_kind(KIND_SUSPEND,   5'd31, 32'h0);
      send_kind(KIND_SUSPEND,   5'd3,  32'h0);
      send_kind(KIND_RESUME,    5'd31, 32'hFFFF_FFFF);
      send_kind(KIND_CREATE,    5'd0,  32'hFFFF_FFFF);
      send_kind(KIND_DELAY,     5'd0,  32'd2);
      send_kind(KIND_TICK,      5'd0,  32'h0);
      send_kind(KIND_TICK,      5'd0,  32'h0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               holds_asked++;
            end
            1: begin
               send_idle_pct  = 78;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 78;
            end
            default: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase
         if (phase == 3) begin
            repeat (258) send_kind(KIND_INT_ENTER, 5'($urandom()), $urandom());
            repeat (258) send_kind(KIND_INT_EXIT, 5'($urandom()), $urandom());
         end
         repeat ((phase == 3) ? 150 : 420) send_event(random_event());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d scheduler events and %0d checked results, %0d task switches,",
               events_sent, results_checked, switches_seen);
      $display("under four flow-control mixes, a long output stall and interrupt nesting at its cap.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rtps_pkg.sv
rtl/rtps_delay_store.sv
rtl/rtos_priority_task_scheduler.sv
sim/rtps_checker.sv
sim/rtos_priority_task_scheduler_tb.sv
